[hw/rtl/tcw_pkg.sv]
// shared constants, types and helpers of the text console writer
package tcw_pkg;

  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 64;
  localparam int TAB_STOP = 4;

  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] RESET_COLOR = 8'd7;
  localparam logic [7:0] RESET_COLS  = 8'd80;
  localparam logic [6:0] RESET_ROWS  = 7'd25;

  localparam logic [1:0] OP_STREAM = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] REG_TEXT_COLOR  = 2'd0;
  localparam logic [1:0] REG_SCREEN_COLS = 2'd1;
  localparam logic [1:0] REG_SCREEN_ROWS = 2'd2;

  localparam logic [2:0] K_CHAR    = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_TAB     = 3'd2;
  localparam logic [2:0] K_WRITE   = 3'd3;
  localparam logic [2:0] K_CLEAR   = 3'd4;
  localparam logic [2:0] K_READ    = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] cell_col;
    logic [5:0] cell_row;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic [6:0] cursor_col;
    logic [5:0] cursor_row;
    logic       scrolled;
    logic       ignored;
  } res_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] col,
                                                  input logic [6:0] row);
    int a;
    a = int'(row) * MAX_COLS + int'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

[hw/rtl/tcw_req_if.sv]
// request channel of the console writer
interface tcw_req_if;
  import tcw_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] char_code;
  logic [7:0] cell_color;
  logic [6:0] cell_col;
  logic [5:0] cell_row;
  modport source (output valid, op, char_code, cell_color, cell_col, cell_row, input ready);
  modport sink (input valid, op, char_code, cell_color, cell_col, cell_row, output ready);
endinterface

// response channel of the console writer
interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_char;
  logic [7:0] read_color;
  logic [6:0] cursor_col;
  logic [5:0] cursor_row;
  logic       scrolled;
  logic       ignored;
  modport source (output valid, read_char, read_color, cursor_col, cursor_row, scrolled,
                  ignored, input ready);
  modport sink (input valid, read_char, read_color, cursor_col, cursor_row, scrolled,
                ignored, output ready);
endinterface

[hw/rtl/tcw_ram.sv]
// generic single write port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/tcw_front.sv]
// front end: accepts items, classifies them and queues them for the back end
module tcw_front import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       hold,
  tcw_req_if.sink    req,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);
  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       cls;

  always_comb begin
    cls.char_code  = req.char_code;
    cls.cell_color = req.cell_color;
    cls.cell_col   = req.cell_col;
    cls.cell_row   = req.cell_row;
    unique case (req.op)
      OP_STREAM: begin
        if (req.char_code == CH_NEWLINE) cls.kind = K_NEWLINE;
        else if (req.char_code == CH_TAB) cls.kind = K_TAB;
        else cls.kind = K_CHAR;
      end
      OP_WRITE: cls.kind = K_WRITE;
      OP_CLEAR: cls.kind = K_CLEAR;
      default:  cls.kind = K_READ;
    endcase
  end

  assign req.ready = (count != 2'd2) && !hold;
  assign push      = req.valid && req.ready;
  assign cmd_valid = count != 2'd0;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end
endmodule

[hw/rtl/tcw_back.sv]
// back end: cursor, geometry, screen store sequencing and result register
module tcw_back import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  output logic       init_busy,
  tcw_rsp_if.source  rsp
);
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_TAB    = 4'd2;
  localparam logic [3:0] S_RDWAIT = 4'd3;
  localparam logic [3:0] S_SCR_RD = 4'd4;
  localparam logic [3:0] S_SCR_WR = 4'd5;
  localparam logic [3:0] S_BLANK  = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;

  logic [3:0] state, state_next;
  logic [6:0] cur_col, cur_col_next;
  logic [5:0] cur_row, cur_row_next;
  logic [7:0] color, color_next;
  logic [7:0] cols, cols_next;
  logic [6:0] rows, rows_next;
  logic [7:0] lc, lc_next;
  logic [6:0] lr, lr_next;
  logic [ADDR_W-1:0] init_addr;
  logic       res_valid;
  res_t       res, res_next;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  logic       out_free, emit, fin, on_screen;
  logic [7:0] fin_col, nc, cv;
  logic [6:0] fin_row, rv;
  logic [7:0] e_ch, e_co;
  logic       e_scr, e_ign;

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign out_free  = !res_valid || rsp.ready;
  assign init_busy = state == S_INIT;
  assign on_screen = ({1'b0, cmd.cell_col} < cols) && ({1'b0, cmd.cell_row} < rows);
  assign nc        = {1'b0, cur_col} + 8'd1;

  always_comb begin
    state_next   = state;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    color_next   = color;
    cols_next    = cols;
    rows_next    = rows;
    lc_next      = lc;
    lr_next      = lr;
    we      = 1'b0;
    waddr   = cell_addr({1'b0, cur_col}, {1'b0, cur_row});
    wdata   = {color, CH_SPACE};
    raddr   = cell_addr({1'b0, cmd.cell_col}, {1'b0, cmd.cell_row});
    cmd_pop = 1'b0;
    emit    = 1'b0;
    fin     = 1'b0;
    fin_col = 8'd0;
    fin_row = 7'd0;
    e_ch    = 8'd0;
    e_co    = 8'd0;
    e_scr   = 1'b0;
    e_ign   = 1'b0;
    cv      = 8'd1;
    rv      = 7'd1;

    unique case (state)
      S_INIT: begin
        we    = 1'b1;
        waddr = init_addr;
        wdata = {RESET_COLOR, CH_SPACE};
        if (init_addr == ADDR_W'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            K_CHAR: begin
              we    = 1'b1;
              wdata = {color, cmd.char_code};
              fin   = 1'b1;
              if (nc >= cols) begin
                fin_col = 8'd0;
                fin_row = {1'b0, cur_row} + 7'd1;
              end else begin
                fin_col = nc;
                fin_row = {1'b0, cur_row};
              end
            end
            K_NEWLINE: begin
              fin     = 1'b1;
              fin_col = 8'd0;
              fin_row = {1'b0, cur_row} + 7'd1;
            end
            K_TAB: state_next = S_TAB;
            K_WRITE: begin
              we    = on_screen;
              waddr = cell_addr({1'b0, cmd.cell_col}, {1'b0, cmd.cell_row});
              wdata = {cmd.cell_color, cmd.char_code};
              emit  = 1'b1;
              e_ign = !on_screen;
            end
            K_CLEAR: begin
              lc_next    = 8'd0;
              lr_next    = 7'd0;
              state_next = S_CLEAR;
            end
            default: begin
              if (on_screen) begin
                state_next = S_RDWAIT;
              end else begin
                emit  = 1'b1;
                e_ign = 1'b1;
              end
            end
          endcase
        end
      end
      S_TAB: begin
        we = 1'b1;
        if (nc < cols && (nc % TAB_STOP) != 0 && (nc + 8'd1) < cols) begin
          cur_col_next = nc[6:0];
        end else begin
          fin = 1'b1;
          if (nc >= cols) begin
            fin_col = 8'd0;
            fin_row = {1'b0, cur_row} + 7'd1;
          end else begin
            fin_col = nc;
            fin_row = {1'b0, cur_row};
          end
        end
      end
      S_RDWAIT: begin
        emit       = 1'b1;
        e_ch       = rdata[7:0];
        e_co       = rdata[15:8];
        state_next = S_IDLE;
      end
      S_SCR_RD: begin
        raddr      = cell_addr(lc, lr + 7'd1);
        state_next = S_SCR_WR;
      end
      S_SCR_WR: begin
        we         = 1'b1;
        waddr      = cell_addr(lc, lr);
        wdata      = rdata;
        state_next = S_SCR_RD;
        if (lc + 8'd1 == cols) begin
          lc_next = 8'd0;
          if (lr + 7'd2 == rows) state_next = S_BLANK;
          else lr_next = lr + 7'd1;
        end else begin
          lc_next = lc + 8'd1;
        end
      end
      S_BLANK: begin
        we    = 1'b1;
        waddr = cell_addr(lc, rows - 7'd1);
        if (lc + 8'd1 == cols) begin
          cur_row_next = 6'(rows - 7'd1);
          emit         = 1'b1;
          e_scr        = 1'b1;
          state_next   = S_IDLE;
        end else begin
          lc_next = lc + 8'd1;
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cell_addr(lc, lr);
        if (lc + 8'd1 == cols) begin
          lc_next = 8'd0;
          if (lr + 7'd1 == rows) begin
            cur_col_next = 7'd0;
            cur_row_next = 6'd0;
            emit         = 1'b1;
            state_next   = S_IDLE;
          end else begin
            lr_next = lr + 7'd1;
          end
        end else begin
          lc_next = lc + 8'd1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (fin) begin
      cur_col_next = fin_col[6:0];
      if (fin_row >= rows) begin
        lc_next    = 8'd0;
        lr_next    = 7'd0;
        state_next = (rows > 7'd1) ? S_SCR_RD : S_BLANK;
      end else begin
        cur_row_next = fin_row[5:0];
        emit         = 1'b1;
        state_next   = S_IDLE;
      end
    end

    if (cfg_we) begin
      unique case (cfg_index)
        REG_TEXT_COLOR: color_next = cfg_data;
        REG_SCREEN_COLS: begin
          if (cfg_data == 8'd0) cv = 8'd1;
          else if (int'(cfg_data) > MAX_COLS) cv = 8'(MAX_COLS);
          else cv = cfg_data;
          cols_next = cv;
          if ({1'b0, cur_col_next} >= cv) cur_col_next = 7'(cv - 8'd1);
        end
        REG_SCREEN_ROWS: begin
          if (cfg_data[6:0] == 7'd0) rv = 7'd1;
          else if (int'(cfg_data[6:0]) > MAX_ROWS) rv = 7'(MAX_ROWS);
          else rv = cfg_data[6:0];
          rows_next = rv;
          if ({1'b0, cur_row_next} >= rv) cur_row_next = 6'(rv - 7'd1);
        end
        default: ;
      endcase
    end

    res_next.read_char  = e_ch;
    res_next.read_color = e_co;
    res_next.cursor_col = cur_col_next;
    res_next.cursor_row = cur_row_next;
    res_next.scrolled   = e_scr;
    res_next.ignored    = e_ign;
  end

  always_ff @(posedge clk) begin
    lc <= lc_next;
    lr <= lr_next;
    if (emit) res <= res_next;
    if (rst) begin
      state     <= S_INIT;
      init_addr <= '0;
      cur_col   <= 7'd0;
      cur_row   <= 6'd0;
      color     <= RESET_COLOR;
      cols      <= RESET_COLS;
      rows      <= RESET_ROWS;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_addr <= init_addr + ADDR_W'(1);
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      color     <= color_next;
      cols      <= cols_next;
      rows      <= rows_next;
      if (emit) res_valid <= 1'b1;
      else if (rsp.ready) res_valid <= 1'b0;
    end
  end

  assign rsp.valid      = res_valid;
  assign rsp.read_char  = res.read_char;
  assign rsp.read_color = res.read_color;
  assign rsp.cursor_col = res.cursor_col;
  assign rsp.cursor_row = res.cursor_row;
  assign rsp.scrolled   = res.scrolled;
  assign rsp.ignored    = res.ignored;
endmodule

[hw/rtl/text_console_writer_top.sv]
// top level of the text console writer
// usage: items enter on req (op, char_code, cell_color, cell_col, cell_row) and
// each gives exactly one result on rsp, in order, with the cursor after the op.
// configuration: cfg_we with cfg_index 0 text_color, 1 screen_cols, 2 screen_rows,
// written only while no item is in flight; geometry writes clamp the cursor.
// the front end queues up to two classified items; the back end runs one at a time.
// a plain character, newline, positioned write or off-screen access passes the queue
// and the result register; a cell read also waits in S_RDWAIT for the store read.
// a tab writes one space per padding cell (up to 4) in S_TAB.
// a scroll copies each cell up a row in S_SCR_RD and S_SCR_WR, then blanks the last row;
// a clear writes all rows*cols cells, one cell write per cycle.
// after reset the store is swept to spaces in colour 7; during the sweep
// req.ready stays low; configuration writes are taken throughout.
// a stalled rsp holds its result; the back end starts no new item until the
// result register is free, and the queue then fills and drops req.ready.
module text_console_writer_top import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  tcw_req_if.sink    req,
  tcw_rsp_if.source  rsp
);
  logic cmd_valid;
  logic cmd_pop;
  logic init_busy;
  cmd_t cmd;

  tcw_front u_front (
    .clk(clk), .rst(rst), .hold(init_busy), .req(req),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  tcw_back u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .init_busy(init_busy),
    .rsp(rsp)
  );

`ifndef NO_ASSERTIONS
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    init_busy |-> !req.ready) else $error("item taken during store sweep");
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop from empty queue");
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.ignored |-> rsp.read_char == 8'd0 && rsp.read_color == 8'd0)
    else $error("ignored result carries read data");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid) else $error("result right after reset");
`endif
endmodule
